// ----- rtl/lonlat_to_half_mesh_code_unit_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the half-mesh code unit
// Implication checks, same-cycle and next-cycle, compiled out for synthesis.
// ----------------------------------------------------------------------------
`ifndef LONLAT_TO_HALF_MESH_CODE_UNIT_ASSERT_SVH
`define LONLAT_TO_HALF_MESH_CODE_UNIT_ASSERT_SVH

`ifndef SYNTHESIS

// check cons in the same cycle as ante
`define LTHMC_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("lthmc: same-cycle check failed");

// check cons in the cycle after ante
`define LTHMC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("lthmc: next-cycle check failed");

`else

`define LTHMC_ASSERT_IMPLY(label, clk, rst, ante, cons)
`define LTHMC_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// ----- rtl/lthmc_pkg.sv -----
// ----------------------------------------------------------------------------
// lthmc_pkg
// Widths, grid constants and stage types of the half-mesh code unit.
// ----------------------------------------------------------------------------
`default_nettype none

package lthmc_pkg;

   // field and bus widths
   localparam int LAT_W      = 21;
   localparam int LON_W      = 23;
   localparam int CODE_W     = 30;
   localparam int REQ_DATA_W = 48;
   localparam int RSP_DATA_W = 32;
   localparam int RSP_USER_W = 1;

   // grid steps in 1/8 arcsecond
   localparam logic [LON_W-1:0] LON_ORIGIN    = 23'd2880000;
   localparam int               LAT_PRIMARY   = 19200;
   localparam int               LAT_SECONDARY = 2400;
   localparam int               LAT_HALF      = 120;
   localparam int               LON_DEGREE    = 28800;
   localparam int               LON_SECONDARY = 3600;
   localparam int               LON_HALF      = 180;

   // reciprocal division: primary steps are 128 * 150 and 128 * 225
   localparam int              PRE_SHIFT   = 7;
   localparam int              RECIP_SHIFT = 24;
   localparam logic [16:0]     LAT_RECIP   = 17'd111849;
   localparam logic [16:0]     LON_RECIP   = 17'd74566;

   // code assembly
   localparam int              DIGIT_PAIR_MAX = 99;
   localparam logic [CODE_W-1:0] CODE_MAX     = 30'd999977994;

   // after the primary division
   typedef struct packed {
      logic [LAT_W-1:0] lat;
      logic [LON_W-1:0] lon_off;
      logic [6:0]       p;
      logic [7:0]       u;
      logic             west;
   } lthmc_quot_type;

   // all digits of one code
   typedef struct packed {
      logic [6:0] p;
      logic [6:0] u;
      logic [2:0] q;
      logic [2:0] v;
      logic [3:0] r;
      logic [3:0] w;
      logic [2:0] m;
      logic       oor;
   } lthmc_digit_type;

   // pipeline control shared by all stages
   typedef struct packed {
      logic advance;
   } lthmc_ctrl_type;

endpackage

`default_nettype wire

// ----- rtl/lthmc_quot.sv -----
// ----------------------------------------------------------------------------
// lthmc_quot
// Longitude offset, then primary row and degree column by reciprocal multiply.
// ----------------------------------------------------------------------------
`default_nettype none

module lthmc_quot (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire lthmc_pkg::lthmc_ctrl_type  ctrl,
   input  wire logic                       in_valid,
   input  wire logic [lthmc_pkg::LAT_W-1:0] in_lat,
   input  wire logic [lthmc_pkg::LON_W-1:0] in_lon,
   output logic                            out_valid,
   output lthmc_pkg::lthmc_quot_type       out_quot
);
   import lthmc_pkg::*;

   logic             valid1_ff;
   logic [LAT_W-1:0] lat1_ff, lat1_in;
   logic [LON_W-1:0] lon_off1_ff, lon_off1_in;
   logic             west1_ff, west1_in;

   logic             valid2_ff;
   lthmc_quot_type   quot2_ff, quot2_in;

   logic [30:0]      lat_prod;
   logic [32:0]      lon_prod;

   // stage 1: offset from 100 degrees east
   always_comb begin
      lat1_in     = in_lat;
      lon_off1_in = in_lon - LON_ORIGIN;
      west1_in    = (in_lon < LON_ORIGIN);
   end

   // stage 2: floor divide by the primary steps
   always_comb begin
      lat_prod = 31'(lat1_ff[LAT_W-1:PRE_SHIFT]) * 31'(LAT_RECIP);
      lon_prod = 33'(lon_off1_ff[LON_W-1:PRE_SHIFT]) * 33'(LON_RECIP);
      quot2_in.lat     = lat1_ff;
      quot2_in.lon_off = lon_off1_ff;
      quot2_in.p       = lat_prod[RECIP_SHIFT +: 7];
      quot2_in.u       = lon_prod[RECIP_SHIFT +: 8];
      quot2_in.west    = west1_ff;
   end

   // advance valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         valid1_ff <= 1'b0;
         valid2_ff <= 1'b0;
      end else if (ctrl.advance) begin
         valid1_ff <= in_valid;
         valid2_ff <= valid1_ff;
      end
   end

   // advance payload
   always_ff @(posedge clock) begin
      if (ctrl.advance) begin
         lat1_ff     <= lat1_in;
         lon_off1_ff <= lon_off1_in;
         west1_ff    <= west1_in;
         quot2_ff    <= quot2_in;
      end
   end

   assign out_valid = valid2_ff;
   assign out_quot  = quot2_ff;

endmodule

`default_nettype wire

// ----- rtl/lthmc_digit.sv -----
// ----------------------------------------------------------------------------
// lthmc_digit
// Remainders, secondary digits, tertiary digits and the quadrant digit.
// ----------------------------------------------------------------------------
`default_nettype none

`include "lonlat_to_half_mesh_code_unit_assert.svh"

module lthmc_digit (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire lthmc_pkg::lthmc_ctrl_type  ctrl,
   input  wire logic                       in_valid,
   input  wire lthmc_pkg::lthmc_quot_type  in_quot,
   output logic                            out_valid,
   output lthmc_pkg::lthmc_digit_type      out_digit
);
   import lthmc_pkg::*;

   // stage 1 registers
   logic        valid1_ff;
   logic [14:0] lat_rem1_ff, lat_rem1_in;
   logic [14:0] lon_rem1_ff, lon_rem1_in;
   logic [6:0]  p1_ff, p1_in;
   logic [6:0]  u1_ff, u1_in;
   logic        oor1_ff, oor1_in;

   // stage 2 registers
   logic        valid2_ff;
   logic [11:0] lat_rem2_ff, lat_rem2_in;
   logic [11:0] lon_rem2_ff, lon_rem2_in;
   logic [2:0]  q2_ff, q2_in;
   logic [2:0]  v2_ff, v2_in;
   logic [6:0]  p2_ff;
   logic [6:0]  u2_ff;
   logic        oor2_ff;

   // stage 3 registers
   logic            valid3_ff;
   lthmc_digit_type digit3_ff, digit3_in;

   logic [LAT_W-1:0] lat_base;
   logic [LON_W-1:0] lon_base;
   logic [4:0]       lat_half_cnt;
   logic [4:0]       lon_half_cnt;

   logic             in_range1;
   logic             digit_legal;

   // stage 1: remainders inside the primary square
   always_comb begin
      lat_base    = LAT_W'(in_quot.p) * LAT_W'(LAT_PRIMARY);
      lon_base    = LON_W'(in_quot.u) * LON_W'(LON_DEGREE);
      lat_rem1_in = 15'(in_quot.lat - lat_base);
      lon_rem1_in = 15'(in_quot.lon_off - lon_base);
      p1_in       = in_quot.p;
      u1_in       = in_quot.u[6:0];
      oor1_in     = in_quot.west || (in_quot.p > 7'(DIGIT_PAIR_MAX))
                    || (in_quot.u > 8'(DIGIT_PAIR_MAX));
   end

   // stage 2: secondary digits from the highest threshold passed
   always_comb begin
      q2_in = '0;
      v2_in = '0;
      for (int k = 1; k < 8; k++) begin
         if (lat_rem1_ff >= 15'(k * LAT_SECONDARY)) q2_in = 3'(k);
         if (lon_rem1_ff >= 15'(k * LON_SECONDARY)) v2_in = 3'(k);
      end
      lat_rem2_in = 12'(lat_rem1_ff - 15'(q2_in) * 15'(LAT_SECONDARY));
      lon_rem2_in = 12'(lon_rem1_ff - 15'(v2_in) * 15'(LON_SECONDARY));
   end

   // stage 3: find the half steps passed, split into tertiary digit and half bit
   always_comb begin
      lat_half_cnt = '0;
      lon_half_cnt = '0;
      for (int k = 1; k < 20; k++) begin
         if (lat_rem2_ff >= 12'(k * LAT_HALF)) lat_half_cnt = 5'(k);
         if (lon_rem2_ff >= 12'(k * LON_HALF)) lon_half_cnt = 5'(k);
      end
      digit3_in.p   = p2_ff;
      digit3_in.u   = u2_ff;
      digit3_in.q   = q2_ff;
      digit3_in.v   = v2_ff;
      digit3_in.r   = lat_half_cnt[4:1];
      digit3_in.w   = lon_half_cnt[4:1];
      digit3_in.m   = {1'b0, lat_half_cnt[0], lon_half_cnt[0]} + 3'd1;
      digit3_in.oor = oor2_ff;
   end

   // advance valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         valid1_ff <= 1'b0;
         valid2_ff <= 1'b0;
         valid3_ff <= 1'b0;
      end else if (ctrl.advance) begin
         valid1_ff <= in_valid;
         valid2_ff <= valid1_ff;
         valid3_ff <= valid2_ff;
      end
   end

   // advance payload
   always_ff @(posedge clock) begin
      if (ctrl.advance) begin
         lat_rem1_ff <= lat_rem1_in;
         lon_rem1_ff <= lon_rem1_in;
         p1_ff       <= p1_in;
         u1_ff       <= u1_in;
         oor1_ff     <= oor1_in;
         lat_rem2_ff <= lat_rem2_in;
         lon_rem2_ff <= lon_rem2_in;
         q2_ff       <= q2_in;
         v2_ff       <= v2_in;
         p2_ff       <= p1_ff;
         u2_ff       <= u1_ff;
         oor2_ff     <= oor1_ff;
         digit3_ff   <= digit3_in;
      end
   end

   assign out_valid = valid3_ff;
   assign out_digit = digit3_ff;

   // terms for the checks below
   assign in_range1   = valid1_ff && !oor1_ff;
   assign digit_legal = (digit3_ff.r <= 4'd9) && (digit3_ff.w <= 4'd9)
                        && (digit3_ff.m >= 3'd1) && (digit3_ff.m <= 3'd4);

   // remainders stay inside their square, so the reciprocal quotients were exact
   `LTHMC_ASSERT_IMPLY(a_lat_rem_bound, clock, reset, valid1_ff, lat_rem1_ff < 15'(LAT_PRIMARY))
   `LTHMC_ASSERT_IMPLY(a_lon_rem_bound, clock, reset, in_range1, lon_rem1_ff < 15'(LON_DEGREE))
   // a code in range reaches the next stage still in range
   `LTHMC_ASSERT_NEXT(a_oor_carry, clock, reset, ctrl.advance && in_range1, valid2_ff && !oor2_ff)
   // decimal digits and quadrant stay legal
   `LTHMC_ASSERT_IMPLY(a_digit_range, clock, reset, valid3_ff && !digit3_ff.oor, digit_legal)

endmodule

`default_nettype wire

// ----- rtl/lthmc_code.sv -----
// ----------------------------------------------------------------------------
// lthmc_code
// Weigh the digits by their decimal places and sum into the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module lthmc_code (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire lthmc_pkg::lthmc_ctrl_type   ctrl,
   input  wire logic                        in_valid,
   input  wire lthmc_pkg::lthmc_digit_type  in_digit,
   output logic                             out_valid,
   output logic [lthmc_pkg::CODE_W-1:0]     out_code,
   output logic                             out_oor
);
   import lthmc_pkg::*;

   logic              valid1_ff;
   logic [CODE_W-1:0] high1_ff, high1_in;
   logic [16:0]       low1_ff, low1_in;
   logic              oor1_ff;

   logic              valid2_ff;
   logic [CODE_W-1:0] code2_ff, code2_in;
   logic              oor2_ff;

   // stage 1: primary pair and lower digits apart
   always_comb begin
      high1_in = CODE_W'(in_digit.p) * CODE_W'(10000000)
               + CODE_W'(in_digit.u) * CODE_W'(100000);
      low1_in  = 17'(in_digit.q) * 17'(10000) + 17'(in_digit.v) * 17'(1000)
               + 17'(in_digit.r) * 17'(100) + 17'(in_digit.w) * 17'(10)
               + 17'(in_digit.m);
   end

   // stage 2: final sum, zero when no code can be formed
   always_comb begin
      code2_in = oor1_ff ? '0 : high1_ff + CODE_W'(low1_ff);
   end

   // advance valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         valid1_ff <= 1'b0;
         valid2_ff <= 1'b0;
      end else if (ctrl.advance) begin
         valid1_ff <= in_valid;
         valid2_ff <= valid1_ff;
      end
   end

   // advance payload, hold while the output is stalled
   always_ff @(posedge clock) begin
      if (ctrl.advance) begin
         high1_ff <= high1_in;
         low1_ff  <= low1_in;
         oor1_ff  <= in_digit.oor;
         code2_ff <= code2_in;
         oor2_ff  <= oor1_ff;
      end
   end

   assign out_valid = valid2_ff;
   assign out_code  = code2_ff;
   assign out_oor   = oor2_ff;

endmodule

`default_nettype wire

// ----- rtl/lonlat_to_half_mesh_code_unit.sv -----
// An accepted item passes the quot, digit and code blocks to its result on rsp_.
// Throughput: one item per cycle; the seven-stage pipeline moves as one and
// stops only while the output register holds a result that is not taken.
// Reset clears the valid bits of every stage; payload registers keep junk.
// ----------------------------------------------------------------------------
// lonlat_to_half_mesh_code_unit
// Longitude and latitude in 1/8 arcsecond to the half-mesh grid square code.
// ----------------------------------------------------------------------------
`default_nettype none

`include "lonlat_to_half_mesh_code_unit_assert.svh"

module lonlat_to_half_mesh_code_unit (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   // [20:0] lat_eighth_arcsec, [43:21] lon_eighth_arcsec, [47:44] zero
   input  wire logic [lthmc_pkg::REQ_DATA_W-1:0]     req_tdata,
   input  wire logic                                 req_tvalid,
   output logic                                      req_tready,
   // [29:0] mesh_code, [31:30] zero
   output logic [lthmc_pkg::RSP_DATA_W-1:0]          rsp_tdata,
   // [0] out_of_range
   output logic [lthmc_pkg::RSP_USER_W-1:0]          rsp_tuser,
   output logic                                      rsp_tvalid,
   input  wire logic                                 rsp_tready
);
   import lthmc_pkg::*;

   lthmc_ctrl_type    ctrl;
   logic              quot_valid;
   lthmc_quot_type    quot;
   logic              digit_valid;
   lthmc_digit_type   digit;
   logic              code_valid;
   logic [CODE_W-1:0] code;
   logic              code_oor;

   // move the whole pipeline unless a result waits at the output
   assign ctrl.advance = !code_valid || rsp_tready;
   assign req_tready   = ctrl.advance;

   lthmc_quot u_quot (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (ctrl),
      .in_valid  (req_tvalid),
      .in_lat    (req_tdata[LAT_W-1:0]),
      .in_lon    (req_tdata[LAT_W +: LON_W]),
      .out_valid (quot_valid),
      .out_quot  (quot)
   );

   lthmc_digit u_digit (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (ctrl),
      .in_valid  (quot_valid),
      .in_quot   (quot),
      .out_valid (digit_valid),
      .out_digit (digit)
   );

   lthmc_code u_code (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (ctrl),
      .in_valid  (digit_valid),
      .in_digit  (digit),
      .out_valid (code_valid),
      .out_code  (code),
      .out_oor   (code_oor)
   );

   // drive the result channel
   assign rsp_tvalid = code_valid;
   assign rsp_tdata  = {(RSP_DATA_W - CODE_W)'(0), code};
   assign rsp_tuser  = code_oor;

   // no code is given for an item out of range
   `LTHMC_ASSERT_IMPLY(a_oor_zero, clock, reset, code_valid && code_oor, code == '0)
   // a valid code always carries a quadrant digit, so it is never zero
   `LTHMC_ASSERT_IMPLY(a_code_nonzero, clock, reset, code_valid && !code_oor, code != '0)
   // a valid code is made of two-digit primary pairs only
   `LTHMC_ASSERT_IMPLY(a_code_max, clock, reset, code_valid && !code_oor, code <= CODE_MAX)

endmodule

`default_nettype wire
